[rtl/aabbto_pkg.sv]
// Shared types and constants of the box-tree overlap tester.
`default_nettype none

package aabbto_pkg;

  localparam int unsigned MaxNodes   = 511;
  localparam int unsigned CoordBits  = 32;
  localparam int unsigned StackDepth = 64;

  localparam int unsigned IdxW    = 9;
  localparam int unsigned NodeAw  = $clog2(MaxNodes);
  localparam int unsigned ChildW  = IdxW + 1;
  localparam int unsigned StackAw = $clog2(StackDepth);
  localparam int unsigned SpW     = $clog2(StackDepth + 1);
  localparam int unsigned SumW    = CoordBits + 1;
  localparam int unsigned CfgAw   = 3;
  localparam int unsigned CfgDw   = 32;

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef enum logic {
    REG_A_COUNT = 1'b0,
    REG_B_COUNT = 1'b1
  } reg_e;

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef struct packed {
    logic   empty;
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
  } node_t;

  localparam int unsigned NodeW = $bits(node_t);

  typedef struct packed {
    logic [IdxW-1:0] i;
    logic [IdxW-1:0] j;
  } pair_t;

  localparam int unsigned PairW = $bits(pair_t);

endpackage

`default_nettype wire

[rtl/aabbto_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module aabbto_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/aabb_tree_overlap_test_core.sv]
// Top level of the box-tree overlap tester: node memories, pair stack and walk sequencer.
`default_nettype none

// A load item writes one node into tree A or B and gives no result.
// A query walks node pairs depth first and returns one overlap_found item; its length
// depends on the data. The root pair and each pair entered as the first child of its
// parent take a node read and a test; each pair taken back from the stack takes a stack
// read, a node read and a test; every further child pair is written to the stack in a
// step of its own, and, when no overlap is found, the walk ends by finding the stack
// empty. A query on a tree with no nodes skips the walk and goes straight to its finish.
// The registered read data of the node memories and the single write port of the pair
// stack set these steps. Input is taken only between queries; a finished result waits
// in an output register, so loads go on while it is not yet taken, and a later query
// holds at its end for as long as that register is still full.
module aabb_tree_overlap_test_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [aabbto_pkg::CfgAw-1:0]      paddr,
  input  wire logic [aabbto_pkg::CfgDw-1:0]      pwdata,
  output logic      [aabbto_pkg::CfgDw-1:0]      prdata,
  output logic                                   pready,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [1:0]                        operation_i,
  input  wire logic [aabbto_pkg::IdxW-1:0]       node_index_i,
  input  wire logic signed [aabbto_pkg::CoordBits-1:0] lo_x_i,
  input  wire logic signed [aabbto_pkg::CoordBits-1:0] lo_y_i,
  input  wire logic signed [aabbto_pkg::CoordBits-1:0] lo_z_i,
  input  wire logic signed [aabbto_pkg::CoordBits-1:0] hi_x_i,
  input  wire logic signed [aabbto_pkg::CoordBits-1:0] hi_y_i,
  input  wire logic signed [aabbto_pkg::CoordBits-1:0] hi_z_i,
  input  wire logic                              node_empty_i,
  input  wire logic signed [aabbto_pkg::CoordBits-1:0] shift_x_i,
  input  wire logic signed [aabbto_pkg::CoordBits-1:0] shift_y_i,
  input  wire logic signed [aabbto_pkg::CoordBits-1:0] shift_z_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic                                   overlap_found_o
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_FETCH = 7'b0000010,
    ST_TEST  = 7'b0000100,
    ST_PUSH  = 7'b0001000,
    ST_POP   = 7'b0010000,
    ST_POPW  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  localparam int unsigned IdxW   = aabbto_pkg::IdxW;
  localparam int unsigned ChildW = aabbto_pkg::ChildW;
  localparam int unsigned SpW    = aabbto_pkg::SpW;

  // True when the translated boxes are apart on this axis.
  function automatic logic axis_apart(aabbto_pkg::coord_t a_lo, aabbto_pkg::coord_t a_hi,
                                      aabbto_pkg::coord_t b_lo, aabbto_pkg::coord_t b_hi,
                                      aabbto_pkg::coord_t s);
    logic signed [aabbto_pkg::SumW-1:0] lo_s, hi_s, a_lo_w, a_hi_w;
    lo_s   = $signed({b_lo[aabbto_pkg::CoordBits-1], b_lo})
           + $signed({s[aabbto_pkg::CoordBits-1], s});
    hi_s   = $signed({b_hi[aabbto_pkg::CoordBits-1], b_hi})
           + $signed({s[aabbto_pkg::CoordBits-1], s});
    a_lo_w = $signed({a_lo[aabbto_pkg::CoordBits-1], a_lo});
    a_hi_w = $signed({a_hi[aabbto_pkg::CoordBits-1], a_hi});
    return (a_lo_w > hi_s) || (a_hi_w < lo_s);
  endfunction

  state_e state_q, state_d;
  logic [IdxW-1:0] cnt_a_q, cnt_b_q;
  aabbto_pkg::coord_t shift_x_q, shift_y_q, shift_z_q;
  logic [SpW-1:0] sp_q, sp_d;
  logic [IdxW-1:0] cur_i_q, cur_i_d, cur_j_q, cur_j_d;
  aabbto_pkg::pair_t kid_q [4];
  aabbto_pkg::pair_t kid_d [4];
  logic [3:0] mask_q, mask_d;
  logic res_q, res_d;
  logic out_valid_q, out_valid_d;
  logic found_q, found_d;

  logic in_acc, cfg_wr;
  logic wr_a, wr_b;
  aabbto_pkg::node_t node_wdata, node_a, node_b;
  logic [aabbto_pkg::NodeAw-1:0] rd_a_addr, rd_b_addr;

  logic stk_we;
  logic [aabbto_pkg::StackAw-1:0] stk_waddr, stk_raddr;
  aabbto_pkg::pair_t stk_wdata, stk_rdata;
  logic [SpW-1:0] sp_m1;

  // Child pair evaluation.
  logic hit, a_leaf, b_leaf, overflow;
  logic [ChildW-1:0] na, nb, i1, i2, j1, j2;
  logic [ChildW-1:0] ci [4];
  logic [ChildW-1:0] cj [4];
  logic [3:0] cv, first_oh;
  logic [2:0] kid_cnt;
  logic [1:0] first_k, push_k;
  logic [SpW:0] sp_need;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite;

  always_comb begin
    unique case (aabbto_pkg::reg_e'(paddr[2]))
      aabbto_pkg::REG_A_COUNT: prdata = aabbto_pkg::CfgDw'(cnt_a_q);
      aabbto_pkg::REG_B_COUNT: prdata = aabbto_pkg::CfgDw'(cnt_b_q);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q <= IdxW'(1);
      cnt_b_q <= IdxW'(1);
    end else if (cfg_wr) begin
      unique case (aabbto_pkg::reg_e'(paddr[2]))
        aabbto_pkg::REG_A_COUNT: cnt_a_q <= pwdata[IdxW-1:0];
        aabbto_pkg::REG_B_COUNT: cnt_b_q <= pwdata[IdxW-1:0];
        default: ;
      endcase
    end
  end

  // Node memories, written straight from a load item.
  assign node_wdata = '{empty: node_empty_i,
                        min_x: lo_x_i, min_y: lo_y_i, min_z: lo_z_i,
                        max_x: hi_x_i, max_y: hi_y_i, max_z: hi_z_i};
  assign wr_a = in_acc && (operation_i == aabbto_pkg::OP_LOAD_A)
             && (node_index_i < IdxW'(aabbto_pkg::MaxNodes));
  assign wr_b = in_acc && (operation_i == aabbto_pkg::OP_LOAD_B)
             && (node_index_i < IdxW'(aabbto_pkg::MaxNodes));

  // A pair taken from the stack addresses the node memories directly.
  assign rd_a_addr = (state_q == ST_POPW) ? stk_rdata.i[aabbto_pkg::NodeAw-1:0]
                                          : cur_i_q[aabbto_pkg::NodeAw-1:0];
  assign rd_b_addr = (state_q == ST_POPW) ? stk_rdata.j[aabbto_pkg::NodeAw-1:0]
                                          : cur_j_q[aabbto_pkg::NodeAw-1:0];

  aabbto_ram #(.Width(aabbto_pkg::NodeW), .Depth(aabbto_pkg::MaxNodes)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (wr_a),
    .waddr_i (node_index_i[aabbto_pkg::NodeAw-1:0]),
    .wdata_i (node_wdata),
    .raddr_i (rd_a_addr),
    .rdata_o (node_a)
  );

  aabbto_ram #(.Width(aabbto_pkg::NodeW), .Depth(aabbto_pkg::MaxNodes)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (wr_b),
    .waddr_i (node_index_i[aabbto_pkg::NodeAw-1:0]),
    .wdata_i (node_wdata),
    .raddr_i (rd_b_addr),
    .rdata_o (node_b)
  );

  // Pair stack.
  assign sp_m1     = sp_q - SpW'(1);
  assign stk_we    = (state_q == ST_PUSH);
  assign stk_waddr = sp_q[aabbto_pkg::StackAw-1:0];
  assign stk_raddr = sp_m1[aabbto_pkg::StackAw-1:0];

  always_comb begin
    push_k = 2'd0;
    for (int k = 0; k < 4; k++) begin
      if (mask_q[k]) begin
        push_k = 2'(k);
      end
    end
  end
  assign stk_wdata = kid_q[push_k];

  aabbto_ram #(.Width(aabbto_pkg::PairW), .Depth(aabbto_pkg::StackDepth)) u_ram_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // Test of the current pair and its children.
  assign hit = !node_a.empty && !node_b.empty
            && !axis_apart(node_a.min_x, node_a.max_x, node_b.min_x, node_b.max_x, shift_x_q)
            && !axis_apart(node_a.min_y, node_a.max_y, node_b.min_y, node_b.max_y, shift_y_q)
            && !axis_apart(node_a.min_z, node_a.max_z, node_b.min_z, node_b.max_z, shift_z_q);

  assign na = {1'b0, cnt_a_q};
  assign nb = {1'b0, cnt_b_q};
  assign i1 = {cur_i_q, 1'b1};
  assign j1 = {cur_j_q, 1'b1};
  assign i2 = i1 + ChildW'(1);
  assign j2 = j1 + ChildW'(1);
  assign a_leaf = (i1 >= na);
  assign b_leaf = (j1 >= nb);

  always_comb begin
    if (a_leaf) begin
      ci[0] = {1'b0, cur_i_q}; cj[0] = j1;
      ci[1] = {1'b0, cur_i_q}; cj[1] = j2;
      ci[2] = na;              cj[2] = nb;
      ci[3] = na;              cj[3] = nb;
    end else if (b_leaf) begin
      ci[0] = i1; cj[0] = {1'b0, cur_j_q};
      ci[1] = i2; cj[1] = {1'b0, cur_j_q};
      ci[2] = na; cj[2] = nb;
      ci[3] = na; cj[3] = nb;
    end else begin
      ci[0] = i1; cj[0] = j1;
      ci[1] = i1; cj[1] = j2;
      ci[2] = i2; cj[2] = j1;
      ci[3] = i2; cj[3] = j2;
    end
  end

  always_comb begin
    kid_cnt  = 3'd0;
    first_k  = 2'd0;
    first_oh = 4'b0000;
    for (int k = 0; k < 4; k++) begin
      cv[k] = (ci[k] < na) && (cj[k] < nb);
      kid_cnt = kid_cnt + 3'(cv[k]);
    end
    for (int k = 3; k >= 0; k--) begin
      if (cv[k]) begin
        first_k = 2'(k);
      end
    end
    first_oh[first_k] = 1'b1;
  end

  // Every valid child pair must fit on the stack, or the walk gives up with a hit.
  assign sp_need  = {1'b0, sp_q} + (SpW + 1)'(kid_cnt);
  assign overflow = (sp_need > (SpW + 1)'(aabbto_pkg::StackDepth));

  always_comb begin
    state_d     = state_q;
    sp_d        = sp_q;
    cur_i_d     = cur_i_q;
    cur_j_d     = cur_j_q;
    kid_d       = kid_q;
    mask_d      = mask_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    found_d     = found_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (operation_i == aabbto_pkg::OP_QUERY)) begin
          sp_d    = '0;
          cur_i_d = '0;
          cur_j_d = '0;
          res_d   = 1'b0;
          if ((cnt_a_q == '0) || (cnt_b_q == '0)) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        state_d = ST_TEST;
      end
      ST_TEST: begin
        if (!hit) begin
          state_d = ST_POP;
        end else if ((a_leaf && b_leaf) || overflow) begin
          res_d   = 1'b1;
          state_d = ST_DONE;
        end else begin
          // The first valid child is walked at once; the rest go on the stack.
          cur_i_d = ci[first_k][IdxW-1:0];
          cur_j_d = cj[first_k][IdxW-1:0];
          for (int k = 0; k < 4; k++) begin
            kid_d[k] = '{i: ci[k][IdxW-1:0], j: cj[k][IdxW-1:0]};
          end
          mask_d  = cv & ~first_oh;
          state_d = ((cv & ~first_oh) != 4'b0000) ? ST_PUSH : ST_FETCH;
        end
      end
      ST_PUSH: begin
        sp_d = sp_q + SpW'(1);
        mask_d[push_k] = 1'b0;
        if (mask_d == 4'b0000) begin
          state_d = ST_FETCH;
        end
      end
      ST_POP: begin
        if (sp_q == '0) begin
          res_d   = 1'b0;
          state_d = ST_DONE;
        end else begin
          sp_d    = sp_m1;
          state_d = ST_POPW;
        end
      end
      ST_POPW: begin
        cur_i_d = stk_rdata.i;
        cur_j_d = stk_rdata.j;
        state_d = ST_TEST;
      end
      ST_DONE: begin
        if (!out_valid_d) begin
          out_valid_d = 1'b1;
          found_d     = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sp_q        <= '0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (operation_i == aabbto_pkg::OP_QUERY)) begin
      shift_x_q <= shift_x_i;
      shift_y_q <= shift_y_i;
      shift_z_q <= shift_z_i;
    end
    cur_i_q <= cur_i_d;
    cur_j_q <= cur_j_d;
    kid_q   <= kid_d;
    res_q   <= res_d;
    found_q <= found_d;
  end

  assign out_valid_o     = out_valid_q;
  assign overlap_found_o = found_q;

endmodule

`default_nettype wire

[rtl/aabbto_check.sv]
// Port-level checker of the box-tree overlap tester and its bind to the top level.
`default_nettype none

module aabbto_check (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_o,
  input wire logic [1:0]                   operation_i,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire logic                         overlap_found_o
);

  // A result that is not taken stays, unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(overlap_found_o))
    else $error("result item dropped or changed while stalled");

  // A query keeps the input closed while it walks the trees.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (operation_i == aabbto_pkg::OP_QUERY) |=> !in_ready_o)
    else $error("input still open in the cycle after a query item");

  // Loads and unused operations never block the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (operation_i != aabbto_pkg::OP_QUERY) |=> in_ready_o)
    else $error("input closed after a non-query item");

  // A new result only appears at the end of a query.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result item appeared without a query in progress");

endmodule

bind aabb_tree_overlap_test_core aabbto_check u_aabbto_check (.*);

`default_nettype wire
